>>> hw/rtl/yuyv_pkg.sv
package yuyv_pkg;

    // Field and accumulator widths
    localparam int unsigned PIX_W     = 8;
    localparam int unsigned FRAC_BITS = 14;
    localparam int unsigned ACC_W     = 24;   // signed Q14 channel sum
    localparam int unsigned LUMA_W    = 22;   // unsigned Q14 luma sum
    localparam int unsigned NUM_PIX   = 2;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_ORDER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAY_MODE     = 1'd1;

    // Channel order codes
    localparam logic ORDER_RGB = 1'b0;
    localparam logic ORDER_BGR = 1'b1;

    // Q14 chroma coefficients
    localparam logic signed [ACC_W-1:0] COEF_RV = 24'sd23060;
    localparam logic signed [ACC_W-1:0] COEF_GU = 24'sd5661;
    localparam logic signed [ACC_W-1:0] COEF_GV = 24'sd11746;
    localparam logic signed [ACC_W-1:0] COEF_BU = 24'sd29147;

    // Q14 BT.709 luma weights
    localparam logic [LUMA_W-1:0] LUMA_R    = 22'd3483;
    localparam logic [LUMA_W-1:0] LUMA_G    = 22'd11718;
    localparam logic [LUMA_W-1:0] LUMA_B    = 22'd1183;
    localparam logic [LUMA_W-1:0] LUMA_HALF = 22'd8192;

    typedef struct packed {
        logic [PIX_W-1:0] r;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] b;
    } rgb_t;

    typedef struct packed {
        logic [LUMA_W-1:0] r;
        logic [LUMA_W-1:0] g;
        logic [LUMA_W-1:0] b;
    } luma_prod_t;

    // Drop the fraction bits and saturate to 0..255
    function automatic logic [PIX_W-1:0] clamp_q14(input logic signed [ACC_W-1:0] acc);
        logic [PIX_W-1:0] res;
        if (acc[ACC_W-1]) begin
            res = '0;
        end else if (acc[ACC_W-2:FRAC_BITS+PIX_W] != '0) begin
            res = '1;
        end else begin
            res = acc[FRAC_BITS+PIX_W-1:FRAC_BITS];
        end
        return res;
    endfunction

endpackage

>>> hw/rtl/yuyv_to_rgb888_converter_unit.sv
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+------------------------------------------
// in       | sink      | in_valid / in_ready    | luma_first, chroma_blue, luma_second,
//          |           |                        | chroma_red
// out      | source    | out_valid / out_ready  | first_chan0..2, second_chan0..2
// cfg      | sink      | cfg_we (no wait)       | cfg_index, cfg_data
//
// Four register stages: chroma products, Q14 sums with clamp, luma products,
// luma sum with gray substitution, channel select and output register. One beat
// is taken per cycle while in_ready is high; each stage loads when it is empty or
// the stage after it moves, so a stall at the output fills the bubbles before
// in_ready drops. Reset clears the stage valid bits and both configuration registers.
module yuyv_to_rgb888_converter_unit
    import yuyv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [PIX_W-1:0]      luma_first,
    input  logic [PIX_W-1:0]      chroma_blue,
    input  logic [PIX_W-1:0]      luma_second,
    input  logic [PIX_W-1:0]      chroma_red,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PIX_W-1:0]      first_chan0,
    output logic [PIX_W-1:0]      first_chan1,
    output logic [PIX_W-1:0]      first_chan2,
    output logic [PIX_W-1:0]      second_chan0,
    output logic [PIX_W-1:0]      second_chan1,
    output logic [PIX_W-1:0]      second_chan2,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers
    logic order_reg;
    logic gray_reg;

    // Stage valid bits and advance enables
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s1_adv, s2_adv, s3_adv, s4_adv;

    // Stage 1: luma samples and chroma products
    logic [PIX_W-1:0]        s1_luma_reg [NUM_PIX];
    logic signed [ACC_W-1:0] s1_rv_reg, s1_gu_reg, s1_gv_reg, s1_bu_reg;
    logic signed [ACC_W-1:0] s1_rv_next, s1_gu_next, s1_gv_next, s1_bu_next;
    logic signed [PIX_W-1:0] du, dv;
    logic [PIX_W-1:0]        in_luma [NUM_PIX];

    // Stage 2..4 payload
    rgb_t       s2_pix_reg  [NUM_PIX];
    rgb_t       s2_pix_next [NUM_PIX];
    rgb_t       s3_pix_reg  [NUM_PIX];
    luma_prod_t s3_prod_reg [NUM_PIX];
    luma_prod_t s3_prod_next[NUM_PIX];
    rgb_t       s4_pix_reg  [NUM_PIX];
    rgb_t       s4_pix_next [NUM_PIX];

    // Take a configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= ORDER_RGB;
            gray_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CHANNEL_ORDER: order_reg <= cfg_data[0];
                CFG_GRAY_MODE:     gray_reg  <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // Advance a stage when it is empty or the next one moves
    assign s4_adv   = !s4_valid_reg || out_ready;
    assign s3_adv   = !s3_valid_reg || s4_adv;
    assign s2_adv   = !s2_valid_reg || s3_adv;
    assign s1_adv   = !s1_valid_reg || s2_adv;
    assign in_ready = s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv) s1_valid_reg <= in_valid;
            if (s2_adv) s2_valid_reg <= s1_valid_reg;
            if (s3_adv) s3_valid_reg <= s2_valid_reg;
            if (s4_adv) s4_valid_reg <= s3_valid_reg;
        end
    end

    // Stage 1: remove the chroma offset and form the chroma products
    assign du = $signed({~chroma_blue[PIX_W-1], chroma_blue[PIX_W-2:0]});
    assign dv = $signed({~chroma_red[PIX_W-1], chroma_red[PIX_W-2:0]});
    assign in_luma[0] = luma_first;
    assign in_luma[1] = luma_second;

    always_comb
    begin
        s1_rv_next = ACC_W'(dv) * COEF_RV;
        s1_gu_next = ACC_W'(du) * COEF_GU;
        s1_gv_next = ACC_W'(dv) * COEF_GV;
        s1_bu_next = ACC_W'(du) * COEF_BU;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s1_luma_reg <= in_luma;
            s1_rv_reg   <= s1_rv_next;
            s1_gu_reg   <= s1_gu_next;
            s1_gv_reg   <= s1_gv_next;
            s1_bu_reg   <= s1_bu_next;
        end
    end

    for (genvar p = 0; p < NUM_PIX; p++)
    begin : g_pix
        logic signed [ACC_W-1:0] base;
        logic [LUMA_W-1:0]       luma_sum;
        logic [PIX_W-1:0]        gray;
        rgb_t                    sel;

        // Stage 2: Q14 channel sums, truncate and clamp
        assign base = $signed({2'b00, s1_luma_reg[p], {FRAC_BITS{1'b0}}});
        assign s2_pix_next[p].r = clamp_q14(base + s1_rv_reg);
        assign s2_pix_next[p].g = clamp_q14(base - s1_gu_reg - s1_gv_reg);
        assign s2_pix_next[p].b = clamp_q14(base + s1_bu_reg);

        // Stage 3: luma weight products
        assign s3_prod_next[p].r = LUMA_W'(s2_pix_reg[p].r) * LUMA_R;
        assign s3_prod_next[p].g = LUMA_W'(s2_pix_reg[p].g) * LUMA_G;
        assign s3_prod_next[p].b = LUMA_W'(s2_pix_reg[p].b) * LUMA_B;

        // Stage 4: luma sum, gray substitution and channel order
        assign luma_sum = s3_prod_reg[p].r + s3_prod_reg[p].g + s3_prod_reg[p].b
                        + LUMA_HALF;
        assign gray = luma_sum[FRAC_BITS+PIX_W-1:FRAC_BITS];

        always_comb
        begin
            if (gray_reg)
            begin
                sel.r = gray;
                sel.g = gray;
                sel.b = gray;
            end
            else
            begin
                sel = s3_pix_reg[p];
            end
            s4_pix_next[p].g = sel.g;
            if (order_reg == ORDER_BGR)
            begin
                s4_pix_next[p].r = sel.b;
                s4_pix_next[p].b = sel.r;
            end
            else
            begin
                s4_pix_next[p].r = sel.r;
                s4_pix_next[p].b = sel.b;
            end
        end
    end

    // Hold payload on stall, advance otherwise
    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            s2_pix_reg <= s2_pix_next;
        end
        if (s3_adv)
        begin
            s3_pix_reg  <= s2_pix_reg;
            s3_prod_reg <= s3_prod_next;
        end
        if (s4_adv)
        begin
            s4_pix_reg <= s4_pix_next;
        end
    end

    // Output beat; r and b slots already carry the selected order
    assign out_valid    = s4_valid_reg;
    assign first_chan0  = s4_pix_reg[0].r;
    assign first_chan1  = s4_pix_reg[0].g;
    assign first_chan2  = s4_pix_reg[0].b;
    assign second_chan0 = s4_pix_reg[1].r;
    assign second_chan1 = s4_pix_reg[1].g;
    assign second_chan2 = s4_pix_reg[1].b;

endmodule

>>> hw/rtl/yuyv_checker.sv
module yuyv_checker
    import yuyv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_ready,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [PIX_W-1:0]      first_chan0,
    input  logic [PIX_W-1:0]      first_chan1,
    input  logic [PIX_W-1:0]      first_chan2,
    input  logic [PIX_W-1:0]      second_chan0,
    input  logic [PIX_W-1:0]      second_chan1,
    input  logic [PIX_W-1:0]      second_chan2,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Track gray mode from the configuration port
    logic gray_shadow_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gray_shadow_reg <= 1'b0;
        end
        else if (cfg_we && cfg_index == CFG_GRAY_MODE)
        begin
            gray_shadow_reg <= cfg_data[0];
        end
    end

    // A stalled output beat stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output beat dropped while stalled");

    // A stalled output beat keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(first_chan0) && $stable(first_chan1)
            && $stable(first_chan2) && $stable(second_chan0)
            && $stable(second_chan1) && $stable(second_chan2))
        else $error("output payload changed while stalled");

    // An empty output stage means the pipeline can take a beat
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // Gray mode writes one luma value to all channels of each pixel
    a_gray_equal: assert property (@(posedge clk) disable iff (!rst_n)
        gray_shadow_reg && out_valid |-> first_chan0 == first_chan1
            && first_chan1 == first_chan2 && second_chan0 == second_chan1
            && second_chan1 == second_chan2)
        else $error("gray pixel channels differ");

endmodule

bind yuyv_to_rgb888_converter_unit yuyv_checker u_yuyv_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .first_chan0  (first_chan0),
    .first_chan1  (first_chan1),
    .first_chan2  (first_chan2),
    .second_chan0 (second_chan0),
    .second_chan1 (second_chan1),
    .second_chan2 (second_chan2),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
);

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench
    import yuyv_pkg::*;
();

    localparam int FRAC_W       = 14;
    localparam int Q14_RV       = 23060;
    localparam int Q14_GU       = 5661;
    localparam int Q14_GV       = 11746;
    localparam int Q14_BU       = 29147;
    localparam int LUMA_WR      = 3483;
    localparam int LUMA_WG      = 11718;
    localparam int LUMA_WB      = 1183;
    localparam int LUMA_ROUND   = 8192;
    localparam int CHROMA_ZERO  = 128;
    localparam int PIPE_LATENCY = 8;
    localparam int DRAIN_LIMIT  = 20000;

    typedef struct packed {
        logic [PIX_W-1:0] luma_first;
        logic [PIX_W-1:0] chroma_blue;
        logic [PIX_W-1:0] luma_second;
        logic [PIX_W-1:0] chroma_red;
    } yuyv_group_t;

    typedef struct packed {
        logic [PIX_W-1:0] c0;
        logic [PIX_W-1:0] c1;
        logic [PIX_W-1:0] c2;
    } chan_triplet_t;

    typedef struct packed {
        chan_triplet_t first;
        chan_triplet_t second;
    } pixel_pair_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [PIX_W-1:0]      luma_first;
    logic [PIX_W-1:0]      chroma_blue;
    logic [PIX_W-1:0]      luma_second;
    logic [PIX_W-1:0]      chroma_red;
    logic                  out_valid;
    logic                  out_ready;
    logic [PIX_W-1:0]      first_chan0;
    logic [PIX_W-1:0]      first_chan1;
    logic [PIX_W-1:0]      first_chan2;
    logic [PIX_W-1:0]      second_chan0;
    logic [PIX_W-1:0]      second_chan1;
    logic [PIX_W-1:0]      second_chan2;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Predictor copy of the configuration
    logic order_bgr;
    logic gray_on;

    pixel_pair_t pending_pixel_pairs[$];
    int          error_count;
    int          groups_sent;
    int          pairs_checked;
    bit [3:0]    modes_seen;
    bit          tx_idle_on;
    bit          rx_idle_on;
    int          rx_hold_cycles;

    yuyv_to_rgb888_converter_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .luma_first   (luma_first),
        .chroma_blue  (chroma_blue),
        .luma_second  (luma_second),
        .chroma_red   (chroma_red),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .first_chan0  (first_chan0),
        .first_chan1  (first_chan1),
        .first_chan2  (first_chan2),
        .second_chan0 (second_chan0),
        .second_chan1 (second_chan1),
        .second_chan2 (second_chan2),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Drop the fraction bits and saturate to the byte range
    function automatic int sat_q14(input int acc);
        int whole;
        if (acc < 0)
            return 0;
        whole = acc >>> FRAC_W;
        return (whole > 255) ? 255 : whole;
    endfunction

    // Convert one luma sample with the shared chroma offsets
    function automatic chan_triplet_t pixel_from_ycc(input logic [PIX_W-1:0] y,
                                                     input int du, input int dv);
        int base;
        int red;
        int green;
        int blue;
        int gray;
        chan_triplet_t px;
        base  = int'(y) << FRAC_W;
        red   = sat_q14(base + Q14_RV * dv);
        green = sat_q14(base - Q14_GU * du - Q14_GV * dv);
        blue  = sat_q14(base + Q14_BU * du);
        // Luma is taken from the true channels, before any reordering
        if (gray_on)
        begin
            gray  = (LUMA_WR * red + LUMA_WG * green + LUMA_WB * blue + LUMA_ROUND) >>> FRAC_W;
            red   = gray;
            green = gray;
            blue  = gray;
        end
        if (order_bgr == ORDER_BGR)
        begin
            px.c0 = blue[PIX_W-1:0];
            px.c2 = red[PIX_W-1:0];
        end
        else
        begin
            px.c0 = red[PIX_W-1:0];
            px.c2 = blue[PIX_W-1:0];
        end
        px.c1 = green[PIX_W-1:0];
        return px;
    endfunction

    function automatic pixel_pair_t convert_group(input yuyv_group_t g);
        int du;
        int dv;
        pixel_pair_t pair;
        du = int'(g.chroma_blue) - CHROMA_ZERO;
        dv = int'(g.chroma_red) - CHROMA_ZERO;
        pair.first  = pixel_from_ycc(g.luma_first, du, dv);
        pair.second = pixel_from_ycc(g.luma_second, du, dv);
        return pair;
    endfunction

    // Bias bytes toward the ends and toward zero chroma
    function automatic logic [PIX_W-1:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'($urandom_range(120, 136));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic yuyv_group_t random_group();
        yuyv_group_t g;
        g.luma_first  = pick_byte();
        g.chroma_blue = pick_byte();
        g.luma_second = pick_byte();
        g.chroma_red  = pick_byte();
        return g;
    endfunction

    // Offer one group, hold it until accepted, then queue its expected pixels
    task automatic send_group(input yuyv_group_t g);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 8) : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        luma_first  <= g.luma_first;
        chroma_blue <= g.chroma_blue;
        luma_second <= g.luma_second;
        chroma_red  <= g.chroma_red;
        do
            @(posedge clk);
        while (!in_ready);
        pending_pixel_pairs.push_back(convert_group(g));
        groups_sent++;
    endtask

    // Idle the input and wait for every expected pixel pair
    task automatic drain_results();
        int waited;
        waited = 0;
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_pixel_pairs.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        if (pending_pixel_pairs.size() != 0)
        begin
            $error("%0d pixel pairs still missing after drain", pending_pixel_pairs.size());
            error_count++;
        end
        repeat (PIPE_LATENCY) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx == CFG_CHANNEL_ORDER)
            order_bgr = val;
        else if (idx == CFG_GRAY_MODE)
            gray_on = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_mode(input logic bgr, input logic gray);
        drain_results();
        write_reg(CFG_CHANNEL_ORDER, bgr);
        write_reg(CFG_GRAY_MODE, gray);
        modes_seen[{gray, bgr}] = 1'b1;
    endtask

    // Extremes of every field under the reset configuration
    task automatic test_reset_defaults();
        yuyv_group_t groups[8];
        groups[0] = '{8'd0,   8'd0,   8'd0,   8'd0};
        groups[1] = '{8'd255, 8'd255, 8'd255, 8'd255};
        groups[2] = '{8'd0,   8'd128, 8'd255, 8'd128};
        groups[3] = '{8'd255, 8'd0,   8'd0,   8'd255};
        groups[4] = '{8'd0,   8'd255, 8'd255, 8'd0};
        groups[5] = '{8'h55,  8'hAA,  8'hAA,  8'h55};
        groups[6] = '{8'hAA,  8'h55,  8'h55,  8'hAA};
        groups[7] = '{8'd16,  8'd127, 8'd235, 8'd129};
        modes_seen[0] = 1'b1;
        foreach (groups[i])
            send_group(groups[i]);
    endtask

    // Every order and gray setting, with saturation both ways
    task automatic test_register_modes();
        yuyv_group_t groups[4];
        groups[0] = '{8'd255, 8'd0,   8'd255, 8'd255};
        groups[1] = '{8'd0,   8'd255, 8'd0,   8'd0};
        groups[2] = '{8'd200, 8'd90,  8'd30,  8'd170};
        groups[3] = '{8'd16,  8'd128, 8'd235, 8'd128};
        for (int m = 0; m < 4; m++)
        begin
            set_mode(m[0], m[1]);
            foreach (groups[i])
                send_group(groups[i]);
        end
    endtask

    // Random groups over changing settings, with and without idling
    task automatic test_random_stream();
        logic bgr;
        logic gray;
        for (int phase = 0; phase < 8; phase++)
        begin
            bgr  = (phase < 4) ? phase[0] : 1'($urandom_range(0, 1));
            gray = (phase < 4) ? phase[1] : 1'($urandom_range(0, 1));
            set_mode(bgr, gray);
            tx_idle_on = (phase != 2 && phase != 5);
            rx_idle_on = (phase != 3 && phase != 5);
            repeat (120) send_group(random_group());
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // Hold off the output while the input keeps streaming
    task automatic test_output_backpressure();
        drain_results();
        tx_idle_on     = 1'b0;
        rx_hold_cycles = 60;
        repeat (30) send_group(random_group());
        tx_idle_on = 1'b1;
        drain_results();
    endtask

    // Stop sending until the pipeline is empty, then resume
    task automatic test_input_pause();
        repeat (15) send_group(random_group());
        drain_results();
        repeat (15) send_group(random_group());
        drain_results();
    endtask

    function automatic void check_chan(input string name, input logic [PIX_W-1:0] want,
                                       input logic [PIX_W-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Compare each output beat with the oldest expectation
    always @(posedge clk)
    begin : check_results
        pixel_pair_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pixel_pairs.size() == 0)
            begin
                $error("output beat with no expected pixel pair");
                error_count++;
            end
            else
            begin
                want = pending_pixel_pairs.pop_front();
                check_chan("first_chan0",  want.first.c0,  first_chan0);
                check_chan("first_chan1",  want.first.c1,  first_chan1);
                check_chan("first_chan2",  want.first.c2,  first_chan2);
                check_chan("second_chan0", want.second.c0, second_chan0);
                check_chan("second_chan1", want.second.c1, second_chan1);
                check_chan("second_chan2", want.second.c2, second_chan2);
                pairs_checked++;
            end
        end
    end

    // Output side: random stall per beat, or a long hold when requested
    initial
    begin : receiver
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold_cycles != 0)
            begin
                stall          = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            else
            begin
                stall = rx_idle_on ? $urandom_range(0, 8) : 0;
            end
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
        end
    end

    initial
    begin
        #(5_000_000);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        luma_first     = '0;
        chroma_blue    = '0;
        luma_second    = '0;
        chroma_red     = '0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        order_bgr      = ORDER_RGB;
        gray_on        = 1'b0;
        error_count    = 0;
        groups_sent    = 0;
        pairs_checked  = 0;
        modes_seen     = '0;
        tx_idle_on     = 1'b1;
        rx_idle_on     = 1'b1;
        rx_hold_cycles = 0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_register_modes();
        test_output_backpressure();
        test_input_pause();
        test_random_stream();
        drain_results();

        if (pending_pixel_pairs.size() != 0)
        begin
            $error("%0d expected pixel pairs never arrived", pending_pixel_pairs.size());
            error_count++;
        end
        $display("Sent %0d YUYV groups, checked %0d RGB pixel pairs, %0d of 4 order/gray modes",
                 groups_sent, pairs_checked, $countones(modes_seen));
        $display("Covered saturation at both ends, output hold-off and input pauses");
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
